[rtl/mpg_pkg.sv]
package mpg_pkg;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   localparam int unsigned POS_W  = 32;
   localparam int unsigned WIDE_W = 35;
   localparam int unsigned ACC_W  = 34;
   localparam int unsigned GRID_W = 10;
   localparam int unsigned HALF_W = 9;
   localparam int unsigned SPAN_W = 18;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_GEOMETRY = 2'd1,
      STATUS_SPAN     = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } status_type;

   typedef struct packed {
      logic                     seq_first;
      logic                     bad_geom;
      logic                     mismatch;
      logic signed [WIDE_W-1:0] pos_t;
      logic signed [WIDE_W-1:0] pos_h;
      logic signed [WIDE_W-1:0] pos_w;
   } entry_type;

endpackage

[rtl/mpg_front.sv]
module mpg_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_seq_first,
   input  logic                 req_is_image,
   input  logic                 req_image_first,
   input  logic                 req_image_last,
   input  logic [9:0]           req_grid_h,
   input  logic [9:0]           req_grid_w,
   input  logic                 queue_full,
   output logic                 queue_push,
   output mpg_pkg::entry_type   queue_data
);
   import mpg_pkg::*;

   logic [POS_W-1:0]  token_index_ff, token_index_in;
   logic [ACC_W-1:0]  offset_ff, offset_in;
   logic [ACC_W-1:0]  base_ff, base_in;
   logic [HALF_W-1:0] rows_ff, rows_in;
   logic [HALF_W-1:0] cols_ff, cols_in;
   logic [HALF_W-1:0] row_ff, row_in;
   logic [HALF_W-1:0] col_ff, col_in;
   logic [SPAN_W-1:0] span_ff, span_in;

   logic                     accept;
   logic [POS_W-1:0]         idx_cur;
   logic [ACC_W-1:0]         off_cur;
   logic [ACC_W-1:0]         new_base;
   logic [ACC_W-1:0]         base_cur;
   logic [HALF_W-1:0]        rows_cur;
   logic [HALF_W-1:0]        cols_cur;
   logic [HALF_W-1:0]        row_cur;
   logic [HALF_W-1:0]        col_cur;
   logic [SPAN_W-1:0]        span_cur;
   logic [HALF_W-1:0]        col_inc;
   logic                     col_wrap;
   logic [HALF_W-1:0]        col_next;
   logic [HALF_W-1:0]        row_next;
   logic [SPAN_W-1:0]        span_next;
   logic [SPAN_W-1:0]        area;
   logic [HALF_W-1:0]        side;
   logic [ACC_W-1:0]         off_img_next;
   logic signed [WIDE_W-1:0] text_pos;
   logic signed [WIDE_W-1:0] base_pos;
   logic                     geom_bad;

   assign req_stall  = queue_full;
   assign accept     = req_valid && !queue_full;
   assign queue_push = accept;

   assign idx_cur  = req_seq_first ? '0 : token_index_ff;
   assign off_cur  = req_seq_first ? '0 : offset_ff;
   assign new_base = {2'b00, idx_cur} + off_cur;
   assign base_cur = req_image_first ? new_base : base_ff;
   assign rows_cur = req_image_first ? req_grid_h[9:1] : rows_ff;
   assign cols_cur = req_image_first ? req_grid_w[9:1] : cols_ff;
   assign row_cur  = req_image_first ? '0 : row_ff;
   assign col_cur  = req_image_first ? '0 : col_ff;
   assign span_cur = req_image_first ? '0 : span_ff;

   assign col_inc   = col_cur + 9'd1;
   assign col_wrap  = col_inc >= cols_cur;
   assign col_next  = col_wrap ? '0 : col_inc;
   assign row_next  = col_wrap ? row_cur + 9'd1 : row_cur;
   assign span_next = (span_cur != '1) ? span_cur + 18'd1 : span_cur;
   assign area      = SPAN_W'(rows_cur) * SPAN_W'(cols_cur);
   assign side      = (rows_cur > cols_cur) ? rows_cur : cols_cur;
   assign off_img_next = off_cur + {25'd0, side} - {16'd0, span_next};

   assign text_pos = signed'({3'b000, idx_cur}) + signed'({off_cur[ACC_W-1], off_cur});
   assign base_pos = signed'({base_cur[ACC_W-1], base_cur});
   assign geom_bad = (req_grid_h < 10'd2) || (req_grid_w < 10'd2) ||
                     req_grid_h[0] || req_grid_w[0];

   always_comb begin
      queue_data.seq_first = req_seq_first;
      queue_data.bad_geom  = req_is_image && req_image_first && geom_bad;
      queue_data.mismatch  = req_is_image && req_image_last && (span_next != area);
      if (req_is_image) begin
         queue_data.pos_t = base_pos;
         queue_data.pos_h = base_pos + signed'({26'd0, row_cur});
         queue_data.pos_w = base_pos + signed'({26'd0, col_cur});
      end else begin
         queue_data.pos_t = text_pos;
         queue_data.pos_h = text_pos;
         queue_data.pos_w = text_pos;
      end
   end

   always_comb begin
      token_index_in = (idx_cur != '1) ? idx_cur + 32'd1 : idx_cur;
      offset_in      = (req_is_image && req_image_last) ? off_img_next : off_cur;
      base_in        = base_ff;
      rows_in        = rows_ff;
      cols_in        = cols_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      span_in        = span_ff;
      if (req_is_image) begin
         base_in = base_cur;
         rows_in = rows_cur;
         cols_in = cols_cur;
         row_in  = row_next;
         col_in  = col_next;
         span_in = span_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_index_ff <= '0;
         offset_ff      <= '0;
         base_ff        <= '0;
         rows_ff        <= '0;
         cols_ff        <= '0;
         row_ff         <= '0;
         col_ff         <= '0;
         span_ff        <= '0;
      end else if (accept) begin
         token_index_ff <= token_index_in;
         offset_ff      <= offset_in;
         base_ff        <= base_in;
         rows_ff        <= rows_in;
         cols_ff        <= cols_in;
         row_ff         <= row_in;
         col_ff         <= col_in;
         span_ff        <= span_in;
      end
   end

endmodule

[rtl/mpg_queue.sv]
module mpg_queue #(
   parameter int unsigned DEPTH = mpg_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mpg_pkg::entry_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output mpg_pkg::entry_type pop_data
);
   import mpg_pkg::*;

   localparam int unsigned PtrW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CountW = $clog2(DEPTH + 1);

   entry_type         slots_ff [DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0] count_ff, count_in;

   assign full      = count_ff == CountW'(DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_data  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CountW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/mpg_back.sv]
module mpg_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               queue_valid,
   input  mpg_pkg::entry_type queue_data,
   output logic               queue_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [31:0]        rsp_pos_t,
   output logic [31:0]        rsp_pos_h,
   output logic [31:0]        rsp_pos_w,
   output logic [1:0]         rsp_status,
   output logic               rsp_failed
);
   import mpg_pkg::*;

   typedef struct packed {
      logic [POS_W-1:0] value;
      logic             ovf;
   } clamp_type;

   function automatic clamp_type clamp_pos(input logic signed [WIDE_W-1:0] p);
      clamp_type r;
      if (p[WIDE_W-1]) begin
         r.value = '0;
         r.ovf   = 1'b1;
      end else if ((p[33:32] != 2'b00) || (&p[31:0])) begin
         r.value = '1;
         r.ovf   = 1'b1;
      end else begin
         r.value = p[31:0];
         r.ovf   = 1'b0;
      end
      return r;
   endfunction

   logic             valid_ff, valid_in;
   logic             error_ff, error_in;
   logic [POS_W-1:0] pos_t_ff, pos_h_ff, pos_w_ff;
   status_type       status_ff, status_in;
   logic             failed_ff;

   clamp_type  ct, ch, cw;
   logic       err_cur;

   assign queue_pop = queue_valid && (!valid_ff || !rsp_stall);

   assign ct      = clamp_pos(queue_data.pos_t);
   assign ch      = clamp_pos(queue_data.pos_h);
   assign cw      = clamp_pos(queue_data.pos_w);
   assign err_cur = queue_data.seq_first ? 1'b0 : error_ff;

   always_comb begin
      if (queue_data.bad_geom) begin
         status_in = STATUS_GEOMETRY;
      end else if (ct.ovf || ch.ovf || cw.ovf) begin
         status_in = STATUS_OVERFLOW;
      end else if (queue_data.mismatch) begin
         status_in = STATUS_SPAN;
      end else begin
         status_in = STATUS_OK;
      end
      error_in = err_cur || (status_in != STATUS_OK);
      valid_in = queue_pop || (valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         error_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (queue_pop) begin
            error_ff <= error_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         pos_t_ff  <= ct.value;
         pos_h_ff  <= ch.value;
         pos_w_ff  <= cw.value;
         status_ff <= status_in;
         failed_ff <= err_cur;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_pos_t  = pos_t_ff;
   assign rsp_pos_h  = pos_h_ff;
   assign rsp_pos_w  = pos_w_ff;
   assign rsp_status = status_ff;
   assign rsp_failed = failed_ff;

endmodule

[rtl/mrope_position_generator_unit.sv]
// An accepted request is queued, then registered in the back end that drives rsp_.
// One request per cycle is accepted while the queue is not full; the front end
// updates all position state per request and the queue absorbs output stalls.
// Reset is synchronous and active high; it clears the index, offset, span state,
// the sticky error flag and the queue, and leaves no result pending.
module mrope_position_generator_unit #(
   parameter int unsigned QUEUE_DEPTH = mpg_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_seq_first,
   input  logic        req_is_image,
   input  logic        req_image_first,
   input  logic        req_image_last,
   input  logic [9:0]  req_grid_h,
   input  logic [9:0]  req_grid_w,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_pos_t,
   output logic [31:0] rsp_pos_h,
   output logic [31:0] rsp_pos_w,
   output logic [1:0]  rsp_status,
   output logic        rsp_failed
);
   import mpg_pkg::*;

   entry_type push_data;
   entry_type pop_data;
   logic      push;
   logic      full;
   logic      pop;
   logic      not_empty;

   mpg_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_seq_first   (req_seq_first),
      .req_is_image    (req_is_image),
      .req_image_first (req_image_first),
      .req_image_last  (req_image_last),
      .req_grid_h      (req_grid_h),
      .req_grid_w      (req_grid_w),
      .queue_full      (full),
      .queue_push      (push),
      .queue_data      (push_data)
   );

   mpg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_data  (pop_data)
   );

   mpg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_valid (not_empty),
      .queue_data  (pop_data),
      .queue_pop   (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_pos_t   (rsp_pos_t),
      .rsp_pos_h   (rsp_pos_h),
      .rsp_pos_w   (rsp_pos_w),
      .rsp_status  (rsp_status),
      .rsp_failed  (rsp_failed)
   );

endmodule

[test/mrope_position_generator_unit_tb.sv]
`timescale 1ns / 100ps

module mrope_position_generator_unit_tb;
   import mpg_pkg::*;

   localparam int unsigned QUIET_LIMIT = 1000;
   localparam int unsigned SPAN_LIMIT = (1 << SPAN_W) - 1;
   localparam int unsigned LONG_SPAN = 40;
   localparam longint POS_MAX = 64'd4294967295;

   typedef struct packed {
      logic [POS_W-1:0] pos_t;
      logic [POS_W-1:0] pos_h;
      logic [POS_W-1:0] pos_w;
      status_type       status;
      logic             failed;
   } positions_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_seq_first = 1'b0;
   logic              req_is_image = 1'b0;
   logic              req_image_first = 1'b0;
   logic              req_image_last = 1'b0;
   logic [GRID_W-1:0] req_grid_h = '0;
   logic [GRID_W-1:0] req_grid_w = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [POS_W-1:0]  rsp_pos_t;
   logic [POS_W-1:0]  rsp_pos_h;
   logic [POS_W-1:0]  rsp_pos_w;
   logic [1:0]        rsp_status;
   logic              rsp_failed;

   // Mirror of the position state held by the block.
   logic [31:0]       tok_index = '0;
   logic [ACC_W-1:0]  pos_offset = '0;
   logic [ACC_W-1:0]  span_base = '0;
   logic [HALF_W-1:0] half_rows = '0;
   logic [HALF_W-1:0] half_cols = '0;
   logic [HALF_W-1:0] walk_row = '0;
   logic [HALF_W-1:0] walk_col = '0;
   logic [SPAN_W-1:0] span_tokens = '0;
   logic              error_flag = 1'b0;

   positions_type     pending_positions[$];
   int unsigned       tokens_sent = 0;
   int unsigned       failures = 0;
   int unsigned       quiet_cycles = 0;
   bit                sender_idling = 1'b1;
   bit                receiver_idling = 1'b1;

   mrope_position_generator_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_seq_first   (req_seq_first),
      .req_is_image    (req_is_image),
      .req_image_first (req_image_first),
      .req_image_last  (req_image_last),
      .req_grid_h      (req_grid_h),
      .req_grid_w      (req_grid_w),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pos_t       (rsp_pos_t),
      .rsp_pos_h       (rsp_pos_h),
      .rsp_pos_w       (rsp_pos_w),
      .rsp_status      (rsp_status),
      .rsp_failed      (rsp_failed)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [POS_W-1:0] clamp_position(input longint p, inout logic ovf);
      if (p < 0) begin
         ovf = 1'b1;
         return '0;
      end
      if (p >= POS_MAX) begin
         ovf = 1'b1;
         return '1;
      end
      return p[POS_W-1:0];
   endfunction

   function automatic positions_type compute_positions(
      input logic seq_first, is_image, image_first, image_last,
      input logic [GRID_W-1:0] grid_h, grid_w);
      positions_type     r;
      logic              bad_geom;
      logic              ovf;
      logic              mismatch;
      longint            pt;
      longint            ph;
      longint            pw;
      logic [HALF_W-1:0] side;
      bad_geom = 1'b0;
      ovf = 1'b0;
      mismatch = 1'b0;
      if (seq_first) begin
         tok_index = '0;
         pos_offset = '0;
         error_flag = 1'b0;
      end
      r.failed = error_flag;
      if (!is_image) begin
         pt = longint'(tok_index) + longint'($signed(pos_offset));
         ph = pt;
         pw = pt;
      end else begin
         if (image_first) begin
            bad_geom = (grid_h < 2) || (grid_w < 2) || grid_h[0] || grid_w[0];
            half_rows = grid_h[GRID_W-1:1];
            half_cols = grid_w[GRID_W-1:1];
            span_base = ACC_W'(tok_index) + pos_offset;
            walk_row = '0;
            walk_col = '0;
            span_tokens = '0;
         end
         pt = longint'($signed(span_base));
         ph = pt + longint'(walk_row);
         pw = pt + longint'(walk_col);
         walk_col = walk_col + HALF_W'(1);
         if (walk_col >= half_cols) begin
            walk_col = '0;
            walk_row = walk_row + HALF_W'(1);
         end
         if (span_tokens != SPAN_W'(SPAN_LIMIT)) span_tokens = span_tokens + SPAN_W'(1);
         if (image_last) begin
            side = (half_rows > half_cols) ? half_rows : half_cols;
            mismatch = 32'(span_tokens) != 32'(half_rows) * 32'(half_cols);
            pos_offset = pos_offset + ACC_W'(side) - ACC_W'(span_tokens);
         end
      end
      r.pos_t = clamp_position(pt, ovf);
      r.pos_h = clamp_position(ph, ovf);
      r.pos_w = clamp_position(pw, ovf);
      if (bad_geom) r.status = STATUS_GEOMETRY;
      else if (ovf) r.status = STATUS_OVERFLOW;
      else if (mismatch) r.status = STATUS_SPAN;
      else r.status = STATUS_OK;
      if (r.status != STATUS_OK) error_flag = 1'b1;
      if (tok_index != '1) tok_index = tok_index + 32'd1;
      return r;
   endfunction

   task automatic send_token(input logic seq_first, is_image, image_first, image_last,
                             input logic [GRID_W-1:0] grid_h, grid_w);
      int unsigned gap;
      @(negedge clock);
      if (sender_idling && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 13);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_seq_first <= seq_first;
      req_is_image <= is_image;
      req_image_first <= image_first;
      req_image_last <= image_last;
      req_grid_h <= grid_h;
      req_grid_w <= grid_w;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_positions.push_back(compute_positions(seq_first, is_image, image_first,
                                                    image_last, grid_h, grid_w));
      tokens_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_positions.size() != 0) @(posedge clock);
   endtask

   task automatic send_noise_token();
      send_token($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 GRID_W'($urandom), GRID_W'($urandom));
   endtask

   task automatic send_text_run();
      int unsigned count;
      count = $urandom_range(1, 6);
      repeat (count) begin
         send_token(1'b0, 1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    GRID_W'($urandom), GRID_W'($urandom));
      end
   endtask

   task automatic send_image_span();
      int unsigned       kind;
      int unsigned       count;
      int unsigned       i;
      logic [GRID_W-1:0] gh;
      logic [GRID_W-1:0] gw;
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
         gh = GRID_W'(2 * $urandom_range(1, 6));
         gw = GRID_W'(2 * $urandom_range(1, 6));
      end else begin
         gh = GRID_W'($urandom);
         gw = GRID_W'($urandom);
      end
      count = 32'(gh[GRID_W-1:1]) * 32'(gw[GRID_W-1:1]);
      if (count == 0 || count > 48 || $urandom_range(0, 7) == 0) count = $urandom_range(1, 12);
      for (i = 0; i < count; i++) begin
         if (i != 0 && $urandom_range(0, 15) == 0) begin
            send_token(1'b0, 1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       GRID_W'($urandom), GRID_W'($urandom));
         end
         send_token(1'b0, 1'b1, i == 0, i == count - 1,
                    (i == 0) ? gh : GRID_W'($urandom), (i == 0) ? gw : GRID_W'($urandom));
      end
   endtask

   task automatic send_sequence();
      int unsigned parts;
      parts = $urandom_range(1, 6);
      send_token(1'b1, 1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 GRID_W'($urandom), GRID_W'($urandom));
      repeat (parts) begin
         if ($urandom_range(0, 1) == 0) send_text_run();
         else send_image_span();
      end
   endtask

   task automatic send_mixed_until(input int unsigned target);
      int unsigned burst;
      while (tokens_sent < target) begin
         if ($urandom_range(0, 9) < 8) begin
            send_sequence();
         end else begin
            burst = $urandom_range(1, 5);
            repeat (burst) send_noise_token();
         end
      end
   endtask

   task automatic test_directed();
      int unsigned i;
      send_token(1'b1, 1'b0, 1'b0, 1'b0, '0, '0);
      send_token(1'b0, 1'b0, 1'b1, 1'b1, '1, '1);
      send_token(1'b0, 1'b1, 1'b1, 1'b0, 10'd4, 10'd6);
      send_token(1'b0, 1'b0, 1'b0, 1'b0, 10'd4, 10'd6);
      for (i = 0; i < 5; i++) send_token(1'b0, 1'b1, 1'b0, i == 4, '0, '0);
      send_token(1'b0, 1'b1, 1'b1, 1'b1, 10'd0, 10'd1023);
      send_token(1'b0, 1'b1, 1'b1, 1'b1, 10'd1023, 10'd2);
      send_token(1'b0, 1'b1, 1'b1, 1'b1, 10'd2, 10'd2);
      send_token(1'b0, 1'b1, 1'b0, 1'b1, '1, '1);
      send_token(1'b0, 1'b1, 1'b0, 1'b1, '0, '0);
      // A span closed again after the sequence restarts drives the offset negative.
      send_token(1'b1, 1'b1, 1'b0, 1'b1, '0, '0);
      send_token(1'b0, 1'b0, 1'b0, 1'b0, '0, '0);
      send_token(1'b0, 1'b0, 1'b0, 1'b0, '1, '0);
      send_token(1'b1, 1'b0, 1'b0, 1'b0, '0, '1);
      send_token(1'b0, 1'b1, 1'b1, 1'b1, 10'd1022, 10'd1022);
      send_token(1'b0, 1'b1, 1'b1, 1'b0, 10'd2, 10'd0);
      send_token(1'b0, 1'b1, 1'b0, 1'b0, '0, '0);
      send_token(1'b0, 1'b1, 1'b0, 1'b1, '0, '0);
      wait_drained();
   endtask

   task automatic test_random_sequences();
      send_mixed_until(tokens_sent + 450);
      wait_drained();
      send_mixed_until(tokens_sent + 600);
      wait_drained();
   endtask

   // A span far longer than its grid keeps walking rows past the last one.
   task automatic test_long_span();
      int unsigned i;
      sender_idling = 1'b0;
      receiver_idling = 1'b0;
      send_token(1'b1, 1'b0, 1'b0, 1'b0, '0, '0);
      send_token(1'b0, 1'b1, 1'b1, 1'b0, 10'd2, 10'd6);
      for (i = 0; i < LONG_SPAN; i++) begin
         send_token(1'b0, 1'b1, 1'b0, i == LONG_SPAN - 1, GRID_W'($urandom), GRID_W'($urandom));
      end
      send_token(1'b0, 1'b0, 1'b0, 1'b0, '0, '0);
      wait_drained();
   endtask

   task automatic test_steady_stream();
      sender_idling = 1'b0;
      receiver_idling = 1'b0;
      send_mixed_until(tokens_sent + 250);
      wait_drained();
   endtask

   initial begin
      int unsigned burst;
      burst = 0;
      forever begin
         @(negedge clock);
         if (burst != 0) burst--;
         else if (receiver_idling && $urandom_range(0, 5) == 0) burst = $urandom_range(1, 13);
         rsp_stall <= (burst != 0);
      end
   end

   task automatic check_field(input string name, input logic [31:0] want, got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      positions_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_positions.size() == 0) begin
            $error("result with no request outstanding");
            failures++;
         end else begin
            want = pending_positions.pop_front();
            check_field("pos_t", want.pos_t, rsp_pos_t);
            check_field("pos_h", want.pos_h, rsp_pos_h);
            check_field("pos_w", want.pos_w, rsp_pos_w);
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("failed", 32'(want.failed), 32'(rsp_failed));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_sequences();
      test_long_span();
      test_steady_stream();
      repeat (10) @(posedge clock);
      if (pending_positions.size() != 0) failures++;
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
